[src/cspr_pkg.sv]
`timescale 1ns / 1ps
// Shared types and codes of the CSP channel rendezvous block.
package cspr_pkg;

	localparam int unsigned ID_W        = 8;
	localparam int unsigned OP_W        = 2;
	localparam int unsigned CODE_W      = 3;
	localparam int unsigned PTR_W       = 32;
	localparam int unsigned SIZE_W      = 32;
	localparam int unsigned SLOTS_W     = 5;
	localparam int unsigned MAX_RESULTS = 3;
	localparam int unsigned RES_CNT_W   = 2;

	// Requester ids are folded into this many distinct values.
	localparam int unsigned REQUEST_IDS = 256;

	typedef enum logic [OP_W-1:0] {
		OP_READ   = 2'd0,
		OP_WRITE  = 2'd1,
		OP_POISON = 2'd2
	} op_t;

	typedef enum logic [CODE_W-1:0] {
		RC_READ_OK   = 3'd0,
		RC_WRITE_OK  = 3'd1,
		RC_POISONED  = 3'd2,
		RC_NACK      = 3'd3,
		RC_POISON_OK = 3'd4
	} rsp_code_t;

	typedef struct packed {
		logic [PTR_W-1:0]  ptr;
		logic [SIZE_W-1:0] size;
	} item_t;

	typedef struct packed {
		logic [ID_W-1:0] writer;
		item_t           item;
	} queue_entry_t;

	typedef struct packed {
		logic [ID_W-1:0]   target_request_id;
		logic [CODE_W-1:0] response_code;
		logic [PTR_W-1:0]  item_pointer;
		logic [SIZE_W-1:0] item_size;
		logic              last_result;
	} result_t;

	typedef struct packed {
		logic                               valid;
		logic [RES_CNT_W-1:0]               count;
		result_t [MAX_RESULTS-1:0]          res;
	} push_t;

endpackage

[src/cspr_req_if.sv]
`timescale 1ns / 1ps
// Request channel: read, write and poison requests into the channel.
interface cspr_req_if;
	import cspr_pkg::*;

	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     operation;
	logic [ID_W-1:0]     request_id;
	logic [PTR_W-1:0]    data_pointer;
	logic [SIZE_W-1:0]   data_size;

	modport source (output valid, operation, request_id, data_pointer, data_size,
		input ready);
	modport sink (input valid, operation, request_id, data_pointer, data_size,
		output ready);
endinterface

[src/cspr_rsp_if.sv]
`timescale 1ns / 1ps
// Completion channel: one completion per requester whose operation finishes.
interface cspr_rsp_if;
	import cspr_pkg::*;

	logic                valid;
	logic                ready;
	logic [ID_W-1:0]     target_request_id;
	logic [CODE_W-1:0]   response_code;
	logic [PTR_W-1:0]    item_pointer;
	logic [SIZE_W-1:0]   item_size;
	logic                last_result;

	modport source (output valid, target_request_id, response_code, item_pointer,
		item_size, last_result, input ready);
	modport sink (input valid, target_request_id, response_code, item_pointer,
		item_size, last_result, output ready);
endinterface

[src/cspr_cfg_if.sv]
`timescale 1ns / 1ps
// Configuration write channel carrying the buffer_slots register.
interface cspr_cfg_if;
	import cspr_pkg::*;

	logic                valid;
	logic                ready;
	logic [SLOTS_W-1:0]  buffer_slots;

	modport source (output valid, buffer_slots, input ready);
	modport sink (input valid, buffer_slots, output ready);
endinterface

[src/csp_channel_rendezvous.sv]
`timescale 1ns / 1ps
// Top level of the CSP channel rendezvous block.
//
//   channel  modport  direction  payload
//   req      sink     in         operation, request_id, data_pointer, data_size
//   rsp      source   out        target_request_id, response_code, item_pointer,
//                                item_size, last_result
//   cfg      sink     in         buffer_slots (always ready)
//
// A request is taken in ST_IDLE, which also starts the queue memory read at the
// head and the tail. ST_EVAL evaluates it against the read data and the channel
// state and hands 0 to 2 completions to the result buffer, which sends one per
// cycle while rsp.ready is high. The next request is accepted while completions
// still drain, but its evaluation waits for the buffer to empty.
// Reset clears the control state and the result buffer at once; the queue memory
// is not cleared, since only occupied entries are ever used.
// A stalled completion channel holds the evaluation step and with it req.ready.
module csp_channel_rendezvous import cspr_pkg::*; #(
	parameter int unsigned FIFO_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	cspr_req_if.sink    req,
	cspr_rsp_if.source  rsp,
	cspr_cfg_if.sink    cfg
);

	localparam int unsigned IDX_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);
	localparam int unsigned SUM_W = CNT_W + 1;

	typedef enum logic {
		ST_IDLE,
		ST_EVAL
	} state_t;

	// Sequencer and channel state.
	state_t             state_q;
	logic [IDX_W-1:0]   head_q;
	logic [CNT_W-1:0]   count_q;
	logic               waiting_q;
	logic [ID_W-1:0]    wid_q;
	logic               poisoned_q;
	logic [SLOTS_W-1:0] slots_q;

	// The request under evaluation.
	logic [OP_W-1:0]    op_q;
	logic [ID_W-1:0]    id_q;
	logic [PTR_W-1:0]   ptr_q;
	logic [SIZE_W-1:0]  size_q;

	logic [ID_W-1:0]    id_mod_tbl [256];

	logic               req_acc;
	logic               buf_empty;
	logic               commit;
	logic [CNT_W-1:0]   lim;
	logic               full;
	logic [IDX_W-1:0]   tail_rd_addr;
	logic [IDX_W-1:0]   tail_wr_addr;
	item_t              head_item;
	logic [ID_W-1:0]    tail_writer;
	queue_entry_t       wr_entry;
	logic               enqueue;
	push_t              push;

	logic [IDX_W-1:0]   head_d;
	logic [CNT_W-1:0]   count_d;
	logic               waiting_d;
	logic [ID_W-1:0]    wid_d;
	logic               poisoned_d;

	function automatic logic [IDX_W-1:0] wrap_idx(input logic [SUM_W-1:0] s);
		if (s >= SUM_W'(FIFO_DEPTH)) begin
			return IDX_W'(s - SUM_W'(FIFO_DEPTH));
		end
		return IDX_W'(s);
	endfunction

	function automatic result_t mk_res(input logic [ID_W-1:0] id,
		input rsp_code_t code, input logic [PTR_W-1:0] ptr,
		input logic [SIZE_W-1:0] size);
		result_t r;
		r.target_request_id = id;
		r.response_code     = code;
		r.item_pointer      = ptr;
		r.item_size         = size;
		r.last_result       = 1'b0;
		return r;
	endfunction

	// Request ids folded to the id range by a constant table.
	for (genvar g = 0; g < 256; g++) begin : g_idmod
		localparam int unsigned MODV = g % REQUEST_IDS;
		assign id_mod_tbl[g] = ID_W'(MODV);
	end

	assign req.ready = (state_q == ST_IDLE);
	assign req_acc   = req.valid && req.ready;
	assign cfg.ready = 1'b1;

	// Occupancy limit: zero acts as one, values past the depth clip to it.
	always_comb begin
		if (slots_q == '0) begin
			lim = CNT_W'(1);
		end else if (32'(slots_q) > 32'(FIFO_DEPTH)) begin
			lim = CNT_W'(FIFO_DEPTH);
		end else begin
			lim = CNT_W'(slots_q);
		end
	end
	assign full = (count_q >= lim);

	// The tail entry is only used when the queue is occupied.
	assign tail_rd_addr = (count_q == '0) ? head_q :
		wrap_idx(SUM_W'(head_q) + SUM_W'(count_q) - SUM_W'(1));
	assign tail_wr_addr = wrap_idx(SUM_W'(head_q) + SUM_W'(count_q));

	cspr_queue_ram #(
		.DEPTH (FIFO_DEPTH),
		.IDX_W (IDX_W)
	) u_ram (
		.clk           (clk),
		.wr_en         (commit && enqueue),
		.wr_addr       (tail_wr_addr),
		.wr_entry      (wr_entry),
		.rd_en         (req_acc),
		.head_addr     (head_q),
		.tail_addr     (tail_rd_addr),
		.head_item_q   (head_item),
		.tail_writer_q (tail_writer)
	);

	assign wr_entry.writer    = id_q;
	assign wr_entry.item.ptr  = ptr_q;
	assign wr_entry.item.size = size_q;

	assign commit = (state_q == ST_EVAL) && buf_empty;

	// Evaluation of one request against the channel state.
	always_comb begin
		logic [RES_CNT_W-1:0] n;
		n          = '0;
		push.res   = '0;
		enqueue    = 1'b0;
		head_d     = head_q;
		count_d    = count_q;
		waiting_d  = waiting_q;
		wid_d      = wid_q;
		poisoned_d = poisoned_q;
		case (op_q)
			OP_READ: begin
				if (waiting_q) begin
					push.res[n] = mk_res(id_q, RC_NACK, '0, '0);
					n = n + 1'b1;
				end else if (count_q != '0) begin
					push.res[n] = mk_res(id_q, RC_READ_OK, head_item.ptr, head_item.size);
					n = n + 1'b1;
					if (full) begin
						// The writer that filled the queue is released by this slot.
						push.res[n] = mk_res(tail_writer, RC_WRITE_OK, '0, '0);
						n = n + 1'b1;
					end
					head_d  = wrap_idx(SUM_W'(head_q) + SUM_W'(1));
					count_d = count_q - CNT_W'(1);
				end else if (poisoned_q) begin
					push.res[n] = mk_res(id_q, RC_POISONED, '0, '0);
					n = n + 1'b1;
				end else begin
					waiting_d = 1'b1;
					wid_d     = id_q;
				end
			end
			OP_WRITE: begin
				if (full) begin
					push.res[n] = mk_res(id_q, RC_NACK, '0, '0);
					n = n + 1'b1;
				end else if (poisoned_q) begin
					push.res[n] = mk_res(id_q, RC_POISONED, '0, '0);
					n = n + 1'b1;
				end else if (waiting_q && count_q == '0) begin
					// Direct hand-over to the waiting reader; nothing is queued.
					push.res[n] = mk_res(wid_q, RC_READ_OK, ptr_q, size_q);
					n = n + 1'b1;
					push.res[n] = mk_res(id_q, RC_WRITE_OK, '0, '0);
					n = n + 1'b1;
					waiting_d = 1'b0;
				end else begin
					enqueue = 1'b1;
					count_d = count_q + CNT_W'(1);
					if (count_q + CNT_W'(1) < lim) begin
						push.res[n] = mk_res(id_q, RC_WRITE_OK, '0, '0);
						n = n + 1'b1;
					end
				end
			end
			OP_POISON: begin
				if (poisoned_q) begin
					push.res[n] = mk_res(id_q, RC_NACK, '0, '0);
					n = n + 1'b1;
				end else begin
					poisoned_d = 1'b1;
					if (waiting_q) begin
						push.res[n] = mk_res(wid_q, RC_POISONED, '0, '0);
						n = n + 1'b1;
					end
					if (count_q != '0 && full) begin
						// The blocked tail writer is poisoned and its entry dropped.
						push.res[n] = mk_res(tail_writer, RC_POISONED, '0, '0);
						n = n + 1'b1;
						count_d = count_q - CNT_W'(1);
					end
					waiting_d = 1'b0;
					push.res[n] = mk_res(id_q, RC_POISON_OK, '0, '0);
					n = n + 1'b1;
				end
			end
			default: begin
				n = '0;
			end
		endcase
		if (n != '0) begin
			push.res[n - 1'b1].last_result = 1'b1;
		end
		push.count = n;
		push.valid = commit && (n != '0);
	end

	cspr_result_buf u_rbuf (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.empty  (buf_empty),
		.rsp    (rsp)
	);

	always_ff @(posedge clk) begin
		if (req_acc) begin
			op_q   <= req.operation;
			id_q   <= id_mod_tbl[req.request_id];
			ptr_q  <= req.data_pointer;
			size_q <= req.data_size;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			head_q     <= '0;
			count_q    <= '0;
			waiting_q  <= 1'b0;
			wid_q      <= '0;
			poisoned_q <= 1'b0;
			slots_q    <= SLOTS_W'(1);
		end else begin
			if (cfg.valid && cfg.ready) begin
				slots_q <= cfg.buffer_slots;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_acc) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (commit) begin
						state_q    <= ST_IDLE;
						head_q     <= head_d;
						count_q    <= count_d;
						waiting_q  <= waiting_d;
						wid_q      <= wid_d;
						poisoned_q <= poisoned_d;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// The queue never holds more entries than it has.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(FIFO_DEPTH))
		else $error("queue occupancy beyond depth");

	// A reader only waits on an empty queue.
	a_wait_empty: assert property (@(posedge clk) disable iff (!arst_n)
		waiting_q |-> count_q == '0)
		else $error("reader waiting while writes are queued");

	// Poison is permanent until reset.
	a_poison_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		poisoned_q |=> poisoned_q)
		else $error("poison flag cleared");

	// The head moves only when an entry is popped.
	a_head_pop: assert property (@(posedge clk) disable iff (!arst_n)
		head_q != $past(head_q) |-> count_q == $past(count_q) - CNT_W'(1))
		else $error("head advanced without a pop");

	// New completions are only loaded into an empty result buffer.
	a_push_empty: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |=> rsp.valid && $past(buf_empty))
		else $error("completions overwritten in the result buffer");

endmodule

[src/cspr_queue_ram.sv]
`timescale 1ns / 1ps
// Pending-write queue storage: item memory read at the head, writer memory at the tail.
module cspr_queue_ram import cspr_pkg::*; #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned IDX_W = 4
) (
	input  logic               clk,
	input  logic               wr_en,
	input  logic [IDX_W-1:0]   wr_addr,
	input  queue_entry_t       wr_entry,
	input  logic               rd_en,
	input  logic [IDX_W-1:0]   head_addr,
	input  logic [IDX_W-1:0]   tail_addr,
	output item_t              head_item_q,
	output logic [ID_W-1:0]    tail_writer_q
);

	item_t           data_mem   [DEPTH];
	logic [ID_W-1:0] writer_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			data_mem[wr_addr]   <= wr_entry.item;
			writer_mem[wr_addr] <= wr_entry.writer;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			head_item_q   <= data_mem[head_addr];
			tail_writer_q <= writer_mem[tail_addr];
		end
	end

endmodule

[src/cspr_result_buf.sv]
`timescale 1ns / 1ps
// Holds the completions of one request and hands them out one per handshake.
module cspr_result_buf import cspr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  push_t             push,
	output logic              empty,
	cspr_rsp_if.source        rsp
);

	result_t              res_q [MAX_RESULTS];
	logic [RES_CNT_W-1:0] cnt_q;
	logic [RES_CNT_W-1:0] idx_q;
	result_t              cur;

	always_ff @(posedge clk) begin
		if (push.valid) begin
			for (int i = 0; i < MAX_RESULTS; i++) begin
				res_q[i] <= push.res[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else if (push.valid) begin
			cnt_q <= push.count;
			idx_q <= '0;
		end else if (rsp.valid && rsp.ready) begin
			if (idx_q + RES_CNT_W'(1) == cnt_q) begin
				cnt_q <= '0;
				idx_q <= '0;
			end else begin
				idx_q <= idx_q + RES_CNT_W'(1);
			end
		end
	end

	assign cur   = res_q[idx_q];
	assign empty = (cnt_q == '0);

	assign rsp.valid             = (cnt_q != '0);
	assign rsp.target_request_id = cur.target_request_id;
	assign rsp.response_code     = cur.response_code;
	assign rsp.item_pointer      = cur.item_pointer;
	assign rsp.item_size         = cur.item_size;
	assign rsp.last_result       = cur.last_result;

endmodule
